### src/gbs_pkg.sv
// gbs_pkg: shared types and constants for the greedy box suppression block.
// No dependencies; imported by greedy_box_suppression, its checker and its testbench.
package gbs_pkg;

  localparam int DEF_MAX_KEPT  = 64;
  localparam int DEF_MAX_BOXES = 1024;

  localparam int COORD_W  = 16;
  localparam int SIZE_W   = 15;
  localparam int AREA_W   = 2 * SIZE_W;
  localparam int UNION_W  = AREA_W + 1;
  localparam int LIMIT_W  = 9;
  localparam int PROD_W   = LIMIT_W + UNION_W;
  localparam int NUMBER_W = 10;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd115;

  typedef struct packed {
    logic [SIZE_W-1:0]  h;
    logic [SIZE_W-1:0]  w;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] x;
  } box_t;

  typedef struct packed {
    logic [AREA_W-1:0] area;
    box_t              box;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_AREA  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

### src/greedy_box_suppression.sv
// greedy_box_suppression: greedy IoU non-maximum suppression over a kept-box list.
// Depends on gbs_pkg (types, widths, reset threshold).
//
// channel  dir  signals                        word
// s        in   s_tvalid s_tready s_tdata s_tuser  one candidate box
// m        out  m_tvalid m_tready m_tdata m_tuser  one verdict per box
// cfg      in   cfg_valid cfg_ready cfg_data       overlap_limit
//
// With K > 0 kept boxes, one IoU test per cycle is issued from the kept-box memory
// into a five-stage compare pipeline, which then drains. The verdict is loaded when
// the pipeline is empty and the output register is free, and the next box can be
// accepted in the cycle after; an empty list skips the scan and the drain.
// s_tready is high only between boxes; a verdict waits in the output register and
// the next box is accepted meanwhile, but a second verdict stalls until the first
// is taken. rst clears the sequencer, counters and threshold; the kept-box memory
// is not cleared. cfg_ready is always high.
module greedy_box_suppression
  import gbs_pkg::*;
#(
  parameter int MAX_KEPT  = DEF_MAX_KEPT,
  parameter int MAX_BOXES = DEF_MAX_BOXES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [63:0]         s_tdata,   // left_edge, top_edge, box_width, box_height, 0
  input  logic                s_tuser,   // frame_start
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [15:0]         m_tdata,   // box_number, 0
  output logic [1:0]          m_tuser,   // kept, list_full
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LIMIT_W-1:0]  cfg_data
);

  localparam int KW = $clog2(MAX_KEPT + 1);
  localparam int IW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_BOXES);
  localparam int PIPE = 5;

  state_t state;

  logic [LIMIT_W-1:0] limit;
  logic [KW-1:0]      kept_total;
  logic [CW-1:0]      box_counter;
  logic [KW-1:0]      scan;
  box_t               nb;
  logic [AREA_W-1:0]  area_a;
  logic               hit;
  logic [PIPE-1:0]    pipe_v;

  entry_t             mem [MAX_KEPT];
  entry_t             rd_q;

  logic [SIZE_W-1:0]  iw_q, ih_q;
  logic [AREA_W-1:0]  area_b_q, area_c_q;
  logic [AREA_W-1:0]  inter_c, inter_d;
  logic [UNION_W-1:0] uni_d;
  logic [PROD_W-1:0]  prod_e, inter_e;

  logic               s_acc, out_free, keep, room;

  // overlap spans, stage B
  logic signed [COORD_W-1:0] nx, ny, kx, ky;
  logic signed [COORD_W:0]   nx_end, ny_end, kx_end, ky_end;
  logic signed [COORD_W:0]   lo_x, hi_x, lo_y, hi_y, dx, dy;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign s_acc     = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign keep      = !hit;
  assign room      = kept_total < KW'(MAX_KEPT);

  always_comb begin
    nx     = $signed(nb.x);
    ny     = $signed(nb.y);
    kx     = $signed(rd_q.box.x);
    ky     = $signed(rd_q.box.y);
    nx_end = {nb.x[COORD_W-1], nb.x} + {2'b00, nb.w};
    ny_end = {nb.y[COORD_W-1], nb.y} + {2'b00, nb.h};
    kx_end = {rd_q.box.x[COORD_W-1], rd_q.box.x} + {2'b00, rd_q.box.w};
    ky_end = {rd_q.box.y[COORD_W-1], rd_q.box.y} + {2'b00, rd_q.box.h};
    lo_x   = (nx > kx) ? {nb.x[COORD_W-1], nb.x} : {rd_q.box.x[COORD_W-1], rd_q.box.x};
    lo_y   = (ny > ky) ? {nb.y[COORD_W-1], nb.y} : {rd_q.box.y[COORD_W-1], rd_q.box.y};
    hi_x   = (nx_end < kx_end) ? nx_end : kx_end;
    hi_y   = (ny_end < ky_end) ? ny_end : ky_end;
    dx     = hi_x - lo_x;
    dy     = hi_y - lo_y;
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      limit       <= LIMIT_RESET;
      kept_total  <= '0;
      box_counter <= '0;
      scan        <= '0;
      hit         <= 1'b0;
      pipe_v      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        limit <= cfg_data;
      end
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      pipe_v <= {pipe_v[PIPE-2:0], state == S_SCAN};
      if (pipe_v[PIPE-1] && ({8'b0, inter_e} > {8'b0, prod_e})) begin
        hit <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (s_acc) begin
            hit   <= 1'b0;
            state <= S_AREA;
            if (s_tuser) begin
              kept_total  <= '0;
              box_counter <= '0;
            end
          end
        end
        S_AREA: begin
          scan  <= '0;
          state <= (kept_total == '0) ? S_DONE : S_SCAN;
        end
        S_SCAN: begin
          scan <= scan + KW'(1);
          if (scan + KW'(1) == kept_total) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (pipe_v == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state       <= S_IDLE;
            box_counter <= (box_counter == CW'(MAX_BOXES - 1)) ? '0 : box_counter + CW'(1);
            if (keep && room) begin
              kept_total <= kept_total + KW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // payload: box latch, output word, compare pipeline
  always_ff @(posedge clk) begin
    if (s_acc) begin
      nb <= box_t'{h: s_tdata[61:47], w: s_tdata[46:32], y: s_tdata[31:16],
                   x: s_tdata[15:0]};
    end
    if (state == S_AREA) begin
      area_a <= nb.w * nb.h;
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {6'b0, NUMBER_W'(box_counter)};
      m_tuser <= {keep && !room, keep};
    end
    iw_q     <= (dx > 17'sd0) ? dx[SIZE_W-1:0] : '0;
    ih_q     <= (dy > 17'sd0) ? dy[SIZE_W-1:0] : '0;
    area_b_q <= rd_q.area;
    inter_c  <= iw_q * ih_q;
    area_c_q <= area_b_q;
    uni_d    <= {1'b0, area_a} + {1'b0, area_c_q} - {1'b0, inter_c};
    inter_d  <= inter_c;
    prod_e   <= limit * uni_d;
    inter_e  <= {2'b00, inter_d, 8'b0};
  end

  // kept-box memory
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free && keep && room) begin
      mem[kept_total[IW-1:0]] <= entry_t'{area: area_a, box: nb};
    end
    if (state == S_SCAN) begin
      rd_q <= mem[scan[IW-1:0]];
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    kept_total <= KW'(MAX_KEPT))
    else $error("kept list count beyond capacity");

  a_load_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |-> (pipe_v == '0))
    else $error("verdict loaded with compares in flight");

  a_full_is_kept: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tuser[0])
    else $error("list_full set on a suppressed box");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (scan < kept_total))
    else $error("scan index past kept list");

endmodule

### tb/greedy_box_suppression_checker.sv
// Scoreboard for greedy_box_suppression: watches the box, verdict and threshold channels,
// predicts each verdict from its own copy of the kept-box list and compares field by field.
// Depends on gbs_pkg for field widths and the reset threshold.
module greedy_box_suppression_checker
  import gbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [63:0]        s_tdata,   // left_edge, top_edge, box_width, box_height, 0
  input  logic               s_tuser,   // frame_start
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [15:0]        m_tdata,   // box_number, 0
  input  logic [1:0]         m_tuser,   // kept, list_full
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [LIMIT_W-1:0] cfg_data,
  output int                 mismatches,
  output int                 awaiting,
  output int                 verdicts,
  output int                 kept_seen,
  output int                 full_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } rect_t;

  typedef struct {
    logic                kept;
    logic [NUMBER_W-1:0] number;
    logic                full;
  } verdict_t;

  rect_t               kept_list[DEF_MAX_KEPT];
  int                  kept_total;
  int                  box_counter;
  logic [LIMIT_W-1:0]  iou_limit;
  verdict_t            pending_verdicts[$];

  function automatic longint span_common(longint a0, longint alen, longint b0, longint blen);
    longint lo;
    longint hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  // IoU above limit/256, cross-multiplied
  function automatic bit too_close(rect_t a, rect_t b);
    longint iw;
    longint ih;
    longint inter;
    longint uni;
    iw    = span_common(a.x, a.w, b.x, b.w);
    ih    = span_common(a.y, a.h, b.y, b.h);
    inter = iw * ih;
    uni   = longint'(a.w) * longint'(a.h) + longint'(b.w) * longint'(b.h) - inter;
    return inter * 256 > longint'(iou_limit) * uni;
  endfunction

  function automatic verdict_t judge_box(logic fresh_frame, logic [63:0] word);
    rect_t    r;
    verdict_t v;
    if (fresh_frame) begin
      kept_total  = 0;
      box_counter = 0;
    end
    r.x = word[15:0];
    r.y = word[31:16];
    r.w = word[46:32];
    r.h = word[61:47];
    v.kept = 1'b1;
    v.full = 1'b0;
    for (int i = 0; i < kept_total; i++) begin
      if (too_close(r, kept_list[i])) begin
        v.kept = 1'b0;
        break;
      end
    end
    if (v.kept) begin
      if (kept_total < DEF_MAX_KEPT) begin
        kept_list[kept_total] = r;
        kept_total++;
      end else begin
        v.full = 1'b1;
      end
    end
    v.number    = box_counter[NUMBER_W-1:0];
    box_counter = (box_counter == DEF_MAX_BOXES - 1) ? 0 : box_counter + 1;
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s at verdict %0d: got %0d, expected %0d", what, verdicts, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    verdict_t fresh;
    if (rst) begin
      kept_total  = 0;
      box_counter = 0;
      iou_limit   = LIMIT_RESET;
      pending_verdicts.delete();
    end else begin
      if (cfg_valid && cfg_ready) iou_limit = cfg_data;
      if (s_tvalid && s_tready) begin
        fresh            = judge_box(s_tuser, s_tdata);
        pending_verdicts = {pending_verdicts, fresh};
      end
      if (m_tvalid && m_tready) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("verdict with no box pending", m_tdata[NUMBER_W-1:0], -1);
        end else begin
          want = pending_verdicts.pop_front();
          if (m_tuser[0] !== want.kept) report_mismatch("kept", m_tuser[0], want.kept);
          if (m_tdata[NUMBER_W-1:0] !== want.number)
            report_mismatch("box_number", m_tdata[NUMBER_W-1:0], want.number);
          if (m_tuser[1] !== want.full) report_mismatch("list_full", m_tuser[1], want.full);
          if (want.kept) kept_seen++;
          if (want.full) full_seen++;
        end
        verdicts++;
      end
    end
    awaiting = pending_verdicts.size();
  end

endmodule

### tb/greedy_box_suppression_tb.sv
// Top of the greedy_box_suppression bench: clock, reset, box and threshold stimulus, verdict.
// Depends on gbs_pkg, greedy_box_suppression and greedy_box_suppression_checker.
module greedy_box_suppression_tb
  import gbs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {FRAME_CLUSTERED, FRAME_TILED, FRAME_MIXED} frame_style_e;
  typedef enum int {PLACE_CLUSTER, PLACE_TILE, PLACE_FLAT, PLACE_WILD} placement_e;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [63:0]        s_tdata;
  logic               s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [15:0]        m_tdata;
  logic [1:0]         m_tuser;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  int mismatches;
  int awaiting;
  int verdicts;
  int kept_seen;
  int full_seen;
  int send_idle;
  int recv_stall;

  greedy_box_suppression uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  greedy_box_suppression_checker scoreboard (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .awaiting  (awaiting),
    .verdicts  (verdicts),
    .kept_seen (kept_seen),
    .full_seen (full_seen)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #10_000_000;
    $display("greedy_box_suppression verification failed");
    $finish;
  end

  function automatic logic [63:0] pack_box(int x, int y, int w, int h);
    return {2'b00, h[SIZE_W-1:0], w[SIZE_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
  endfunction

  function automatic logic [63:0] random_box(frame_style_e style, int tile);
    placement_e place;
    int         pick;
    int         t;
    pick = $urandom_range(99);
    case (style)
      FRAME_CLUSTERED: place = (pick < 80) ? PLACE_CLUSTER : PLACE_WILD;
      FRAME_TILED:     place = (pick < 90) ? PLACE_TILE : PLACE_FLAT;
      default: begin
        if (pick < 35)      place = PLACE_CLUSTER;
        else if (pick < 70) place = PLACE_TILE;
        else if (pick < 85) place = PLACE_FLAT;
        else                place = PLACE_WILD;
      end
    endcase
    t = tile % 1024;
    case (place)
      PLACE_CLUSTER:
        return pack_box($urandom_range(600) - 300, $urandom_range(600) - 300,
                        $urandom_range(400, 1), $urandom_range(400, 1));
      // disjoint 2048-unit grid cells, so tile boxes in distinct cells never suppress one another
      PLACE_TILE:
        return pack_box(-32768 + (t % 32) * 2048, -32768 + (t / 32) * 2048,
                        $urandom_range(2048), $urandom_range(2048));
      PLACE_FLAT:
        if ($urandom_range(1))
          return pack_box($urandom_range(600) - 300, $urandom_range(600) - 300,
                          0, $urandom_range(400));
        else
          return pack_box($urandom_range(600) - 300, $urandom_range(600) - 300,
                          $urandom_range(400), 0);
      default:
        return pack_box($urandom, $urandom, $urandom, $urandom);
    endcase
  endfunction

  task automatic send_box(logic fresh_frame, logic [63:0] word);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    s_tuser  <= fresh_frame;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  task automatic write_limit(int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[LIMIT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int           limit_plan[5];
    int           send_plan[5];
    int           stall_plan[5];
    int           box_plan[5];
    int           sent;
    int           frame_len;
    int           tile;
    frame_style_e style;
    limit_plan = '{128, 0, 256, 511, 77};
    send_plan  = '{0, 74, 0, 7, 0};
    stall_plan = '{0, 0, 74, 7, 0};
    box_plan   = '{1040, 40, 40, 40, 30};
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    send_idle  = 0;
    recv_stall = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed boxes at the reset threshold
    send_box(1'b0, pack_box(-32768, -32768, 32767, 32767));
    send_box(1'b0, pack_box(-32768, -32768, 32767, 32767));  // identical -> suppressed
    send_box(1'b0, pack_box(32767, 32767, 0, 0));
    send_box(1'b0, pack_box(32767, 32767, 0, 0));            // zero union
    send_box(1'b0, pack_box(0, 0, 1600, 1600));
    send_box(1'b0, pack_box(800, 0, 1600, 1600));            // IoU 1/3
    send_box(1'b0, pack_box(320, 0, 1600, 1600));            // IoU 2/3
    send_box(1'b0, pack_box(-1, -1, 1, 1));                  // edges touch only
    send_box(1'b0, pack_box(0, 0, 0, 1600));
    send_box(1'b1, pack_box(0, 0, 1600, 1600));              // new frame clears list
    send_box(1'b0, pack_box(0, 0, 1600, 1600));
    send_box(1'b0, pack_box(2000, 0, 32, 8));
    send_box(1'b0, pack_box(2000, 0, 23, 5));                // IoU exactly at limit
    send_box(1'b0, pack_box(2000, 0, 29, 4));                // one step above
    send_box(1'b0, pack_box(-32768, 32767, 32767, 32767));
    send_box(1'b1, pack_box(32767, -32768, 32767, 0));

    for (int p = 0; p < 5; p++) begin
      wait_drained();
      write_limit(limit_plan[p]);
      send_idle  = send_plan[p];
      recv_stall = stall_plan[p];
      sent = 0;
      while (sent < box_plan[p]) begin
        // first phase is one long frame so the box counter wraps
        frame_len = (p == 0) ? box_plan[p] : $urandom_range(90, 1);
        style     = (p == 0) ? FRAME_MIXED : frame_style_e'($urandom_range(2));
        tile      = $urandom_range(1023);
        for (int k = 0; k < frame_len && sent < box_plan[p]; k++) begin
          send_box(k == 0, random_box(style, tile + k));
          sent++;
        end
      end
    end

    wait_drained();
    repeat (80) @(posedge clk);
    $display("Run covered %0d boxes over six thresholds and four handshake patterns:",
             verdicts);
    $display("  %0d kept (%0d of them past a full list), %0d suppressed",
             kept_seen, full_seen, verdicts - kept_seen);
    if (mismatches == 0) begin
      $display("greedy_box_suppression verification clean");
    end else begin
      $display("greedy_box_suppression verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/gbs_pkg.sv
src/greedy_box_suppression.sv
tb/greedy_box_suppression_checker.sv
tb/greedy_box_suppression_tb.sv
